// File: rtl/core/tak_pkg.sv
// Shared types, constants and fixed-point helpers for the tilt-angle Kalman filter.
package tak_pkg;

    // Fixed-point format of every internal value: signed Q8.40 in 48 bits
    localparam int VALUE_WIDTH   = 48;
    localparam int FRACTION_BITS = 40;

    // Configuration port
    localparam int CFG_W     = 47;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_NOISE = 2'd0,
        CFG_BIAS_NOISE  = 2'd1,
        CFG_MEAS_NOISE  = 2'd2,
        CFG_TIME_STEP   = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] CFG_RST_ANGLE_NOISE = CFG_W'(64'd549755814);
    localparam logic [CFG_W-1:0] CFG_RST_BIAS_NOISE  = CFG_W'(64'd3298535);
    localparam logic [CFG_W-1:0] CFG_RST_MEAS_NOISE  = CFG_W'(64'd21990232556);
    localparam logic [CFG_W-1:0] CFG_RST_TIME_STEP   = CFG_W'(64'd5497558139);

    // Multiplier: one 8-bit digit of the second operand per cycle
    localparam int MUL_DIGIT = 8;
    localparam int MUL_STEPS = (VALUE_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int MUL_BW    = MUL_STEPS * MUL_DIGIT;
    localparam int MUL_AW    = VALUE_WIDTH + MUL_BW;
    localparam int WIDE_W    = MUL_AW + 1;

    // Divider: dividend is magnitude << FRACTION_BITS plus half the divisor
    localparam int DIV_NW = VALUE_WIDTH + FRACTION_BITS + 1;

    // Gyro scale: 2000/32768 deg/s per count in rad/s, as 34.906585 / 32768
    localparam int RATE_GAIN  = 34906585;
    localparam int RATE_SCALE = 1000000;

    typedef logic signed [VALUE_WIDTH-1:0] t_val;
    typedef logic        [VALUE_WIDTH-1:0] t_mag;

    localparam t_val VAL_MAX = t_val'((65'd1 << (VALUE_WIDTH - 1)) - 65'd1);
    localparam t_val VAL_MIN = t_val'(65'd1 << (VALUE_WIDTH - 1));
    localparam t_val ONE_VAL = t_val'(65'd1 << FRACTION_BITS);

    typedef struct packed {
        logic signed [15:0] accel_z_raw;
        logic signed [15:0] gyro_y_raw;
    } t_in_word;

    typedef struct packed {
        t_val angle_estimate;
        t_val rate_estimate;
    } t_out_word;

    // Sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_RATE,
        OP_ANGLE_PRED,
        OP_P00_PRED,
        OP_P01_PRED,
        OP_P11_PRED,
        OP_K0,
        OP_K1,
        OP_P00_UPD,
        OP_P01_UPD,
        OP_P10_UPD,
        OP_P11_UPD,
        OP_ANGLE_UPD,
        OP_BIAS_UPD
    } t_op;

    // Magnitude of a signed value; the most negative value maps to 2^(W-1)
    function automatic t_mag mag(t_val a);
        t_mag u;
        u = t_mag'(a);
        return a[VALUE_WIDTH-1] ? (~u + t_mag'(1)) : u;
    endfunction

    // Apply a sign to a magnitude, saturating to the signed range
    function automatic t_val from_mag(logic [WIDE_W-1:0] m, logic neg, logic ovf);
        logic [WIDE_W-1:0] lim;
        t_mag              r;
        lim = (WIDE_W'(1) << (VALUE_WIDTH - 1)) - (neg ? WIDE_W'(0) : WIDE_W'(1));
        if (ovf || (m > lim)) begin
            r = lim[VALUE_WIDTH-1:0];
        end else begin
            r = m[VALUE_WIDTH-1:0];
        end
        return neg ? t_val'(~r + t_mag'(1)) : t_val'(r);
    endfunction

    function automatic t_val sadd(t_val a, t_val b);
        logic [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            return s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
        end
        return t_val'(s[VALUE_WIDTH-1:0]);
    endfunction

    function automatic t_val ssub(t_val a, t_val b);
        logic [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            return s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
        end
        return t_val'(s[VALUE_WIDTH-1:0]);
    endfunction

    // Register value as a signed operand, clamped to the largest value
    function automatic t_val reg_val(logic [CFG_W-1:0] r);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(r);
        if (w > WIDE_W'(VAL_MAX)) begin
            return VAL_MAX;
        end
        return t_val'(w[VALUE_WIDTH-1:0]);
    endfunction

endpackage

// File: rtl/core/tilt_angle_kalman_filter.sv
// Tilt-angle Kalman filter: angle and gyro bias states, 2x2 covariance, Q8.40.
// One word in gives one word out. A small sequencer runs each word through a shared
// 8-bit-digit multiplier (ten products) and a shared bit-serial divider (up to three
// quotients: the gyro scaling and the two gains, which are set to zero when the
// innovation variance is zero or negative). The input is not ready while a word is
// being worked on. Each write with i_cfg_we high updates its configuration register,
// and the registers feed the arithmetic directly, so a write also reaches a word in
// progress; write them only while the block is idle.
module tilt_angle_kalman_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tak_pkg::t_in_word             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tak_pkg::t_out_word            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [tak_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tak_pkg::CFG_W-1:0]     i_cfg_data
);
    import tak_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [CFG_W-1:0] r_angle_noise, r_bias_noise, r_meas_noise, r_time_step;
    t_val r_angle, r_bias, r_p00, r_p01, r_p10, r_p11;
    t_val r_angle_m, r_rate_m, r_err, r_e, r_k0, r_k1, r_t0, r_t1;
    logic [15:0] r_gyro_mag;
    logic        r_gyro_pos;
    logic        r_out_valid;
    t_out_word   r_out;

    logic  accept, unit_done, is_div, e_pos, skip_k, load_out;
    logic  mul_start, div_start;
    t_val  mul_a, mul_b, div_src, unit_res;
    t_mag  div_den;
    logic  div_neg;
    logic [DIV_NW-1:0] div_num;
    logic  mul_done, div_done;
    t_val  mul_res, div_res;
    t_val  qa, qg, rn, dt;
    logic [15:0] acc_mag, gyr_mag;

    assign qa = reg_val(r_angle_noise);
    assign qg = reg_val(r_bias_noise);
    assign rn = reg_val(r_meas_noise);
    assign dt = reg_val(r_time_step);

    assign accept    = i_in_valid && o_in_ready;
    assign unit_done = mul_done || div_done;
    assign unit_res  = div_done ? div_res : mul_res;
    assign is_div    = (r_op == OP_RATE) || (r_op == OP_K0) || (r_op == OP_K1);
    assign e_pos     = !r_e[VALUE_WIDTH-1] && (r_e != '0);
    assign skip_k    = ((r_op == OP_K0) || (r_op == OP_K1)) && !e_pos;

    assign acc_mag = i_in_data.accel_z_raw[15] ? 16'(-i_in_data.accel_z_raw)
                                               : 16'(i_in_data.accel_z_raw);
    assign gyr_mag = i_in_data.gyro_y_raw[15] ? 16'(-i_in_data.gyro_y_raw)
                                              : 16'(i_in_data.gyro_y_raw);

    // Select operands for the current step
    always_comb begin
        mul_a   = '0;
        mul_b   = dt;
        div_src = r_p00;
        case (r_op)
            OP_ANGLE_PRED: mul_a = ssub(r_rate_m, r_bias);
            OP_P00_PRED:   mul_a = ssub(ssub(qa, r_p01), r_p10);
            OP_P01_PRED:   mul_a = ssub('0, r_p11);
            OP_P11_PRED:   mul_a = qg;
            OP_K1:         div_src = r_p10;
            OP_P00_UPD: begin
                mul_a = r_k0;
                mul_b = r_t0;
            end
            OP_P01_UPD: begin
                mul_a = r_k0;
                mul_b = r_t1;
            end
            OP_P10_UPD: begin
                mul_a = r_k1;
                mul_b = r_t0;
            end
            OP_P11_UPD: begin
                mul_a = r_k1;
                mul_b = r_t1;
            end
            OP_ANGLE_UPD: begin
                mul_a = r_k0;
                mul_b = r_err;
            end
            OP_BIAS_UPD: begin
                mul_a = r_k1;
                mul_b = r_err;
            end
            default: mul_a = '0;
        endcase
        if (r_op == OP_RATE) begin
            div_num = ((DIV_NW'(r_gyro_mag) * DIV_NW'(RATE_GAIN)) << (FRACTION_BITS - 15))
                      + DIV_NW'(RATE_SCALE / 2);
            div_den = t_mag'(RATE_SCALE);
            div_neg = r_gyro_pos;
        end else begin
            div_num = (DIV_NW'(mag(div_src)) << FRACTION_BITS)
                      + DIV_NW'(t_mag'(r_e) >> 1);
            div_den = t_mag'(r_e);
            div_neg = div_src[VALUE_WIDTH-1];
        end
    end

    // Next state, step and unit starts
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        mul_start = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_ISSUE;
                    n_op    = OP_RATE;
                end
            end
            ST_ISSUE: begin
                if (skip_k) begin
                    n_op = (r_op == OP_K0) ? OP_K1 : OP_P00_UPD;
                end else begin
                    mul_start = !is_div;
                    div_start = is_div;
                    n_state   = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (unit_done) begin
                    if (r_op == OP_BIAS_UPD) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ISSUE;
                        n_op    = t_op'(r_op + 4'd1);
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_RATE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_noise <= CFG_RST_ANGLE_NOISE;
            r_bias_noise  <= CFG_RST_BIAS_NOISE;
            r_meas_noise  <= CFG_RST_MEAS_NOISE;
            r_time_step   <= CFG_RST_TIME_STEP;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ANGLE_NOISE: r_angle_noise <= i_cfg_data;
                CFG_BIAS_NOISE:  r_bias_noise  <= i_cfg_data;
                CFG_MEAS_NOISE:  r_meas_noise  <= i_cfg_data;
                CFG_TIME_STEP:   r_time_step   <= i_cfg_data;
                default:         r_time_step   <= r_time_step;
            endcase
        end
    end

    // Filter state: write back the result of each prediction and update step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_bias  <= '0;
            r_p00   <= ONE_VAL;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= ONE_VAL;
        end else if ((r_state == ST_WAIT) && unit_done) begin
            case (r_op)
                OP_ANGLE_PRED: r_angle <= sadd(r_angle, unit_res);
                OP_P00_PRED:   r_p00   <= sadd(r_p00, unit_res);
                OP_P01_PRED: begin
                    r_p01 <= sadd(r_p01, unit_res);
                    r_p10 <= sadd(r_p10, unit_res);
                end
                OP_P11_PRED:   r_p11   <= sadd(r_p11, unit_res);
                OP_P00_UPD:    r_p00   <= ssub(r_p00, unit_res);
                OP_P01_UPD:    r_p01   <= ssub(r_p01, unit_res);
                OP_P10_UPD:    r_p10   <= ssub(r_p10, unit_res);
                OP_P11_UPD:    r_p11   <= ssub(r_p11, unit_res);
                OP_ANGLE_UPD:  r_angle <= sadd(r_angle, unit_res);
                OP_BIAS_UPD:   r_bias  <= sadd(r_bias, unit_res);
                default:       r_angle <= r_angle;
            endcase
        end
    end

    // Per-word temporaries
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_angle_m  <= from_mag(WIDE_W'(acc_mag) << (FRACTION_BITS - 12),
                                   i_in_data.accel_z_raw[15], 1'b0);
            r_gyro_mag <= gyr_mag;
            r_gyro_pos <= !i_in_data.gyro_y_raw[15] && (i_in_data.gyro_y_raw != '0);
        end
        if ((r_state == ST_ISSUE) && skip_k) begin
            if (r_op == OP_K0) begin
                r_k0 <= '0;
            end else begin
                r_k1 <= '0;
            end
        end
        if ((r_state == ST_WAIT) && unit_done) begin
            case (r_op)
                OP_RATE: r_rate_m <= unit_res;
                OP_P11_PRED: begin
                    r_err <= ssub(r_angle_m, r_angle);
                    r_e   <= sadd(rn, r_p00);
                    r_t0  <= r_p00;
                    r_t1  <= r_p01;
                end
                OP_K0:   r_k0 <= unit_res;
                OP_K1:   r_k1 <= unit_res;
                default: r_err <= r_err;
            endcase
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.angle_estimate <= r_angle;
            r_out.rate_estimate  <= ssub(r_rate_m, r_bias);
        end
    end

    tak_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a_mag (mag(mul_a)),
        .i_b_mag (mag(mul_b)),
        .i_neg   (mul_a[VALUE_WIDTH-1] ^ mul_b[VALUE_WIDTH-1]),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    tak_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_neg   (div_neg),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_no_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(mul_done || div_done))
        else $error("arithmetic unit finished while sequencer idle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input still ready after a word was accepted");

    a_one_unit_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_start && div_start))
        else $error("multiplier and divider started together");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten before it was taken");
`endif

endmodule

// File: rtl/core/tak_mul.sv
// Digit-serial signed fixed-point multiplier with round-to-nearest and saturation.
module tak_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tak_pkg::t_mag i_a_mag,
    input  tak_pkg::t_mag i_b_mag,
    input  logic          i_neg,
    output logic          o_done,
    output tak_pkg::t_val o_res
);
    import tak_pkg::*;

    localparam int CW = $clog2(MUL_STEPS + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [MUL_AW-1:0] r_acc;
    logic [MUL_BW-1:0] r_b;
    t_mag              r_a;
    logic              r_neg;
    t_val              r_res;
    logic [WIDE_W-1:0] rounded;
    logic [MUL_AW-1:0] partial;

    // Round half away from zero on the magnitude, then drop fraction bits
    assign rounded = (WIDE_W'(r_acc) + (WIDE_W'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    assign partial = MUL_AW'(r_a) * MUL_AW'(r_b[MUL_BW-1 -: MUL_DIGIT]);

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(MUL_STEPS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    // Accumulate one digit per cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a_mag;
            r_b   <= MUL_BW'(i_b_mag);
            r_neg <= i_neg;
        end else if (r_busy) begin
            if (r_cnt == CW'(MUL_STEPS)) begin
                r_res <= from_mag(rounded, r_neg, 1'b0);
            end else begin
                r_acc <= (r_acc << MUL_DIGIT) + partial;
                r_b   <= r_b << MUL_DIGIT;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: rtl/core/tak_div.sv
// Bit-serial restoring divider producing a saturated signed fixed-point quotient.
module tak_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tak_pkg::DIV_NW-1:0] i_num,
    input  tak_pkg::t_mag              i_den,
    input  logic                       i_neg,
    output logic                       o_done,
    output tak_pkg::t_val              o_res
);
    import tak_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    t_mag                 r_rem;
    t_mag                 r_low;
    t_mag                 r_q;
    t_mag                 r_den;
    logic                 r_neg;
    logic                 r_ovf;
    t_val                 r_res;
    logic [VALUE_WIDTH:0] trial;
    logic                 fits;

    assign trial = {r_rem, r_low[VALUE_WIDTH-1]};
    assign fits  = (trial >= {1'b0, r_den});

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(VALUE_WIDTH)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    // One quotient bit per cycle; flag overflow when the quotient needs more bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= VALUE_WIDTH'(i_num[DIV_NW-1:VALUE_WIDTH]);
            r_low <= i_num[VALUE_WIDTH-1:0];
            r_ovf <= (DIV_NW'(i_num[DIV_NW-1:VALUE_WIDTH]) >= DIV_NW'(i_den));
            r_den <= i_den;
            r_neg <= i_neg;
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_cnt == CW'(VALUE_WIDTH)) begin
                r_res <= from_mag(WIDE_W'(r_q), r_neg, r_ovf);
            end else begin
                r_rem <= fits ? VALUE_WIDTH'(trial - {1'b0, r_den}) : trial[VALUE_WIDTH-1:0];
                r_low <= r_low << 1;
                r_q   <= {r_q[VALUE_WIDTH-2:0], fits};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: tb/tb_tilt_angle_kalman_filter.sv
// Testbench for the tilt-angle Kalman filter: random stimulus, bit-true predictor, checks.
`timescale 1ns / 1ps

module tb_tilt_angle_kalman_filter;
    import tak_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_word             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_word            o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    tilt_angle_kalman_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Predictor state and configuration
    longint filt_angle, filt_bias, p_aa, p_ab, p_ba, p_bb;
    logic [CFG_W-1:0] noise_angle, noise_bias, noise_meas, step_dt;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        error_count;
    int        words_checked;
    bit        calm;
    longint    cycle_count;

    localparam longint VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    function automatic longint sat(logic signed [127:0] x);
        if (x > VMAX) return VMAX;
        if (x < VMIN) return VMIN;
        return longint'(x);
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return sat(128'(signed'(a)) + 128'(signed'(b)));
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        return sat(128'(signed'(a)) - 128'(signed'(b)));
    endfunction

    function automatic logic [127:0] absval(longint a);
        return a < 0 ? 128'(-128'(signed'(a))) : 128'(a);
    endfunction

    // Saturate a magnitude to the signed range, then apply the sign
    function automatic longint signed_from(logic [127:0] m, bit neg);
        logic [127:0] lim;
        lim = neg ? 128'(VMAX) + 1 : 128'(VMAX);
        if (m > lim) m = lim;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        p = (absval(a) * absval(b) + (128'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        return signed_from(p, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_div(longint a, longint b);
        logic [127:0] q;
        q = ((absval(a) << FRACTION_BITS) + (128'(b) >> 1)) / 128'(b);
        return signed_from(q, a < 0);
    endfunction

    function automatic longint reg_operand(logic [CFG_W-1:0] r);
        return longint'(r) > VMAX ? VMAX : longint'(r);
    endfunction

    function automatic void filter_reset();
        noise_angle = CFG_RST_ANGLE_NOISE;
        noise_bias  = CFG_RST_BIAS_NOISE;
        noise_meas  = CFG_RST_MEAS_NOISE;
        step_dt     = CFG_RST_TIME_STEP;
        filt_angle = 0; filt_bias = 0;
        p_aa = longint'(1) << FRACTION_BITS; p_ab = 0; p_ba = 0;
        p_bb = longint'(1) << FRACTION_BITS;
    endfunction

    // Advance the filter by one sample and return the expected output word
    function automatic t_out_word filter_step(t_in_word w);
        longint acc, gyr, qa, qg, rn, dt, angle_m, rate_m, pd0, pd1, err, e, k0, k1, t0, t1;
        logic [127:0] m;
        t_out_word r;
        acc = w.accel_z_raw; gyr = w.gyro_y_raw;
        qa = reg_operand(noise_angle); qg = reg_operand(noise_bias);
        rn = reg_operand(noise_meas);  dt = reg_operand(step_dt);
        k0 = 0; k1 = 0;
        angle_m = signed_from(absval(acc) << (FRACTION_BITS - 12), acc < 0);
        m = ((absval(gyr) * 128'd34906585) << (FRACTION_BITS - 15)) + 128'd500000;
        rate_m = signed_from(m / 128'd1000000, gyr > 0);
        filt_angle = fx_add(filt_angle, fx_mul(fx_sub(rate_m, filt_bias), dt));
        pd0 = fx_sub(fx_sub(qa, p_ab), p_ba);
        pd1 = fx_sub(0, p_bb);
        p_aa = fx_add(p_aa, fx_mul(pd0, dt));
        p_ab = fx_add(p_ab, fx_mul(pd1, dt));
        p_ba = fx_add(p_ba, fx_mul(pd1, dt));
        p_bb = fx_add(p_bb, fx_mul(qg, dt));
        err = fx_sub(angle_m, filt_angle);
        e = fx_add(rn, p_aa);
        if (e > 0) begin
            k0 = fx_div(p_aa, e);
            k1 = fx_div(p_ba, e);
        end
        t0 = p_aa; t1 = p_ab;
        p_aa = fx_sub(p_aa, fx_mul(k0, t0));
        p_ab = fx_sub(p_ab, fx_mul(k0, t1));
        p_ba = fx_sub(p_ba, fx_mul(k1, t0));
        p_bb = fx_sub(p_bb, fx_mul(k1, t1));
        filt_angle = fx_add(filt_angle, fx_mul(k0, err));
        filt_bias  = fx_add(filt_bias, fx_mul(k1, err));
        r.angle_estimate = t_val'(filt_angle);
        r.rate_estimate  = t_val'(fx_sub(rate_m, filt_bias));
        return r;
    endfunction

    // Driver: present pending words, with random idle bursts
    int send_idle;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_idle  <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) expected_words.push_back(filter_step(i_in_data));
            if (send_idle > 0) begin
                send_idle  <= send_idle - 1;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                i_in_data  <= pending_words.pop_front();
                i_in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) send_idle <= $urandom_range(1, 16);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls on the result side, compare each word
    int recv_stall;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_stall  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected output word %h", o_out_data);
                    error_count++;
                end else begin
                    t_out_word x;
                    x = expected_words.pop_front();
                    words_checked++;
                    if (x.angle_estimate !== o_out_data.angle_estimate) begin
                        $error("angle_estimate expected %0d got %0d",
                               x.angle_estimate, o_out_data.angle_estimate);
                        error_count++;
                    end
                    if (x.rate_estimate !== o_out_data.rate_estimate) begin
                        $error("rate_estimate expected %0d got %0d",
                               x.rate_estimate, o_out_data.rate_estimate);
                        error_count++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall  <= recv_stall - 1;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 40) == 0) begin
                recv_stall  <= $urandom_range(1, 16);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2_000_000) begin
            $display("tb_tilt_angle_kalman_filter failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_ANGLE_NOISE: noise_angle = val;
            CFG_BIAS_NOISE:  noise_bias  = val;
            CFG_MEAS_NOISE:  noise_meas  = val;
            default:         step_dt     = val;
        endcase
    endtask

    // Hold until every queued word has been sent and answered, then let the block settle
    task automatic drain();
        while (pending_words.size() > 0 || i_in_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic void queue_word(logic [15:0] a, logic [15:0] g);
        t_in_word w;
        w.accel_z_raw = a;
        w.gyro_y_raw  = g;
        pending_words.push_back(w);
    endfunction

    // Mostly a slowly moving tilt with noise, sometimes full-range samples
    function automatic void queue_random(int n);
        int base;
        base = $urandom_range(0, 8000) - 4000;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_word(16'($urandom), 16'($urandom));
            end else begin
                base += $urandom_range(0, 200) - 100;
                queue_word(16'(base + $urandom_range(0, 64) - 32),
                           16'($urandom_range(0, 2000) - 1000));
            end
        end
    endfunction

    logic [CFG_W-1:0] reg_hi;

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_ready = 1'b0; i_in_data = '0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_ANGLE_NOISE; i_cfg_data = '0;
        error_count = 0; words_checked = 0; calm = 0; cycle_count = 0;
        reg_hi = '1;
        filter_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes at reset settings
        queue_word(16'h0000, 16'h0000);
        queue_word(16'h7fff, 16'h7fff);
        queue_word(16'h8000, 16'h8000);
        queue_word(16'h7fff, 16'h8000);
        queue_word(16'h8000, 16'h7fff);
        queue_word(16'hffff, 16'h0001);
        queue_word(16'h1000, 16'hffff);
        queue_word(16'h5555, 16'haaaa);
        queue_word(16'haaaa, 16'h5555);
        drain();

        // Large noise and time step: saturation everywhere
        write_reg(CFG_ANGLE_NOISE, reg_hi);
        write_reg(CFG_BIAS_NOISE, reg_hi);
        write_reg(CFG_MEAS_NOISE, reg_hi);
        write_reg(CFG_TIME_STEP, reg_hi);
        queue_word(16'h7fff, 16'h8000);
        queue_word(16'h8000, 16'h7fff);
        queue_word(16'h1234, 16'h0000);
        drain();

        // Smallest values; innovation variance can go non-positive
        write_reg(CFG_ANGLE_NOISE, '0);
        write_reg(CFG_BIAS_NOISE, '0);
        write_reg(CFG_MEAS_NOISE, 47'd1);
        write_reg(CFG_TIME_STEP, 47'd1);
        queue_word(16'h4000, 16'h7fff);
        queue_word(16'hc000, 16'h8000);
        drain();
        write_reg(CFG_TIME_STEP, CFG_RST_TIME_STEP << 8);
        queue_random(4);
        drain();

        // Random phases with random settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_ANGLE_NOISE, CFG_W'($urandom_range(0, 1 << 30)));
            write_reg(CFG_BIAS_NOISE, CFG_W'($urandom_range(0, 1 << 24)));
            write_reg(CFG_MEAS_NOISE,
                      (CFG_W'({$urandom, $urandom}) >> $urandom_range(4, 20)) | CFG_W'(1));
            write_reg(CFG_TIME_STEP, CFG_W'($urandom_range(1, 1 << 31)) << 4);
            queue_random(145);
            drain();
        end

        // Reset settings, final stretch; idles and stalls stop partway through
        write_reg(CFG_ANGLE_NOISE, CFG_RST_ANGLE_NOISE);
        write_reg(CFG_BIAS_NOISE, CFG_RST_BIAS_NOISE);
        write_reg(CFG_MEAS_NOISE, CFG_RST_MEAS_NOISE);
        write_reg(CFG_TIME_STEP, CFG_RST_TIME_STEP);
        queue_random(100);
        while (pending_words.size() > 50) @(posedge i_clk);
        calm = 1;
        drain();

        $display("Checked %0d output words over reset, extreme and random settings.",
                 words_checked);
        if (error_count == 0) begin
            $display("tb_tilt_angle_kalman_filter passed");
        end else begin
            $display("tb_tilt_angle_kalman_filter failed");
        end
        $finish;
    end

endmodule
